// File: design/cfcr_pkg.sv
// Shared types and constants for the checksummed command frame receiver.
`default_nettype none
package cfcr_pkg;

    localparam int unsigned CAPTURE_BYTES_DEF = 8;

    localparam logic [7:0]  HDR_FIRST      = 8'hAA;
    localparam logic [7:0]  HDR_SECOND     = 8'hBB;
    localparam logic [15:0] SET_PARAMS_LEN = 16'd8;

    localparam logic [7:0]  TYPE_CODE_RST  = 8'd1;
    localparam logic [15:0] MAX_LEN_RST    = 16'd122;

    localparam logic [7:0]  REG_SET_PARAMS_TYPE = 8'd0;
    localparam logic [7:0]  REG_MAX_PAYLOAD_LEN = 8'd1;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_CSUM_ERR  = 2'd1,
        ST_IGNORED   = 2'd2,
        ST_OVERSIZE  = 2'd3
    } status_t;

    typedef enum logic [6:0] {
        PH_HDR1    = 7'b0000001,
        PH_HDR2    = 7'b0000010,
        PH_TYPE    = 7'b0000100,
        PH_LENLO   = 7'b0001000,
        PH_LENHI   = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_CSUM    = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0]  set_params_type_code;
        logic [15:0] max_payload_length;
    } cfg_t;

    typedef struct packed {
        status_t     frame_status;
        logic [7:0]  frame_type;
        logic [15:0] payload_length;
        logic [15:0] timer_prescale;
        logic [15:0] timer_reload;
        logic [31:0] tone_frequency;
    } result_t;

endpackage
`default_nettype wire

// File: design/cfcr_parser.sv
// Frame parser: per-byte phase step, checksum, payload capture and result build.
`default_nettype none
module cfcr_parser #(
    parameter int unsigned CAPTURE_BYTES = cfcr_pkg::CAPTURE_BYTES_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    input  wire logic [7:0]       in_byte,
    input  cfcr_pkg::cfg_t        cfg,
    output logic                  res_valid,
    output cfcr_pkg::result_t     res
);
    import cfcr_pkg::*;

    localparam int unsigned CAP_W = 8 * CAPTURE_BYTES;

    phase_t             phase_reg,         phase_next;
    logic [7:0]         held_type_reg,     held_type_next;
    logic [15:0]        held_length_reg,   held_length_next;
    logic [15:0]        payload_count_reg, payload_count_next;
    logic [7:0]         running_sum_reg,   running_sum_next;
    logic [CAP_W-1:0]   captured_reg,      captured_next;

    logic [7:0]  sum_add;
    logic [15:0] len_full;
    logic [15:0] count_inc;

    assign sum_add   = running_sum_reg + in_byte;
    assign len_full  = {in_byte, held_length_reg[7:0]};
    assign count_inc = payload_count_reg + 16'd1;

    always_comb begin
        phase_next         = phase_reg;
        held_type_next     = held_type_reg;
        held_length_next   = held_length_reg;
        payload_count_next = payload_count_reg;
        running_sum_next   = running_sum_reg;
        captured_next      = captured_reg;
        res_valid          = 1'b0;
        res                = '0;
        res.frame_type     = held_type_reg;
        res.payload_length = held_length_reg;
        if (in_valid) begin
            unique case (phase_reg)
                PH_HDR1: begin
                    if (in_byte == HDR_FIRST) phase_next = PH_HDR2;
                end
                PH_HDR2: begin
                    phase_next = (in_byte == HDR_SECOND) ? PH_TYPE : PH_HDR1;
                end
                PH_TYPE: begin
                    held_type_next     = in_byte;
                    running_sum_next   = in_byte;
                    held_length_next   = '0;
                    payload_count_next = '0;
                    captured_next      = '0;
                    phase_next         = PH_LENLO;
                end
                PH_LENLO: begin
                    held_length_next = {8'd0, in_byte};
                    running_sum_next = sum_add;
                    phase_next       = PH_LENHI;
                end
                PH_LENHI: begin
                    held_length_next = len_full;
                    running_sum_next = sum_add;
                    if (len_full > cfg.max_payload_length) begin
                        // drop oversize frame at once
                        res_valid          = 1'b1;
                        res.frame_status   = ST_OVERSIZE;
                        res.payload_length = len_full;
                        phase_next         = PH_HDR1;
                    end else begin
                        phase_next = (len_full == 16'd0) ? PH_CSUM : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    running_sum_next = sum_add;
                    for (int i = 0; i < CAPTURE_BYTES; i++) begin
                        if (payload_count_reg == 16'(i)) captured_next[8*i +: 8] = in_byte;
                    end
                    payload_count_next = count_inc;
                    if (count_inc >= held_length_reg) phase_next = PH_CSUM;
                end
                PH_CSUM: begin
                    phase_next = PH_HDR1;
                    res_valid  = 1'b1;
                    if (in_byte != running_sum_reg) begin
                        res.frame_status = ST_CSUM_ERR;
                    end else if (held_type_reg == cfg.set_params_type_code &&
                                 held_length_reg == SET_PARAMS_LEN) begin
                        res.frame_status   = ST_ACCEPTED;
                        res.timer_prescale = captured_reg[15:0];
                        res.timer_reload   = captured_reg[31:16];
                        res.tone_frequency = captured_reg[63:32];
                    end else begin
                        res.frame_status = ST_IGNORED;
                    end
                end
                default: begin
                    phase_next = PH_HDR1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR1;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_type_reg     <= held_type_next;
        held_length_reg   <= held_length_next;
        payload_count_reg <= payload_count_next;
        running_sum_reg   <= running_sum_next;
        captured_reg      <= captured_next;
    end

endmodule
`default_nettype wire

// File: design/cfcr_out_skid.sv
// Result register with a skid stage so the input side keeps moving under stall until the skid stage is full.
`default_nettype none
module cfcr_out_skid (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    input  cfcr_pkg::result_t  in_data,
    output logic               in_ready,
    output logic               out_valid,
    output cfcr_pkg::result_t  out_data,
    input  wire logic          out_ready
);
    import cfcr_pkg::*;

    logic    out_valid_reg,  out_valid_next;
    result_t out_data_reg,   out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg,  skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end else if (in_valid) begin
            // hold the new result behind the stalled one
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule
`default_nettype wire

// File: design/checksummed_command_frame_receiver.sv
// A frame's result is registered to the output, or to the skid stage while stalled.
// One byte per cycle unless stalled; phase step and 8-bit checksum add are combinational.
// A stalled result is held in a one-entry skid stage; s_tready drops only when it is full.
// Reset (aresetn low, synchronous): search restarts at the first header byte, results are
// flushed and the registers return to type code 1 and maximum payload length 122.
`default_nettype none
module checksummed_command_frame_receiver #(
    parameter int unsigned CAPTURE_BYTES = cfcr_pkg::CAPTURE_BYTES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [87:0]       m_tdata,   // [7:0] frame_type, [23:8] payload_length,
                                         // [39:24] timer_prescale, [55:40] timer_reload,
                                         // [87:56] tone_frequency
    output logic [1:0]        m_tuser,   // [1:0] frame_status
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);
    import cfcr_pkg::*;

    cfg_t    cfg_reg;
    logic    in_accept;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.set_params_type_code <= TYPE_CODE_RST;
            cfg_reg.max_payload_length   <= MAX_LEN_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_SET_PARAMS_TYPE) begin
                cfg_reg.set_params_type_code <= cfg_data[7:0];
            end else if (cfg_index == REG_MAX_PAYLOAD_LEN) begin
                cfg_reg.max_payload_length <= cfg_data;
            end
        end
    end

    cfcr_parser #(
        .CAPTURE_BYTES (CAPTURE_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_accept),
        .in_byte   (s_tdata),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    cfcr_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tuser = out_res.frame_status;
    assign m_tdata = {out_res.tone_frequency, out_res.timer_reload, out_res.timer_prescale,
                      out_res.payload_length, out_res.frame_type};

`ifndef ASSERT_OFF
    a_params_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_ACCEPTED |-> m_tdata[87:24] == 64'd0)
        else $error("parameter words set on a result that was not accepted");

    a_accept_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_ACCEPTED |-> m_tdata[23:8] == SET_PARAMS_LEN)
        else $error("accepted frame with wrong payload length");

    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && m_tready |=> s_tready)
        else $error("skid stage did not drain after output transaction");
`endif

endmodule
`default_nettype wire

// File: tb/tb_checksummed_command_frame_receiver.sv
// Testbench for the checksummed command frame receiver: random framed byte streams, outcome checks.
module tb_checksummed_command_frame_receiver;
    import cfcr_pkg::*;

    class frame_outcome_tracker;
        logic [7:0]  type_code;
        logic [15:0] max_len;
        phase_t      phase;
        logic [7:0]  frame_type;
        logic [15:0] frame_len;
        logic [15:0] body_count;
        logic [7:0]  sum;
        logic [63:0] param_bytes;
        result_t     awaited[$];
        int          errors;

        function new();
            type_code   = TYPE_CODE_RST;
            max_len     = MAX_LEN_RST;
            phase       = PH_HDR1;
            frame_type  = '0;
            frame_len   = '0;
            body_count  = '0;
            sum         = '0;
            param_bytes = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [7:0] reg_index, logic [15:0] value);
            if (reg_index == REG_SET_PARAMS_TYPE) begin
                type_code = value[7:0];
            end else if (reg_index == REG_MAX_PAYLOAD_LEN) begin
                max_len = value;
            end
        endfunction

        function void post_outcome(status_t status, logic [63:0] words);
            result_t r;
            r.frame_status   = status;
            r.frame_type     = frame_type;
            r.payload_length = frame_len;
            r.timer_prescale = words[15:0];
            r.timer_reload   = words[31:16];
            r.tone_frequency = words[63:32];
            awaited.push_back(r);
        endfunction

        function void take_byte(logic [7:0] b);
            case (phase)
                PH_HDR1: begin
                    if (b == HDR_FIRST) phase = PH_HDR2;
                end
                PH_HDR2: begin
                    phase = (b == HDR_SECOND) ? PH_TYPE : PH_HDR1;
                end
                PH_TYPE: begin
                    frame_type  = b;
                    sum         = b;
                    frame_len   = '0;
                    body_count  = '0;
                    param_bytes = '0;
                    phase       = PH_LENLO;
                end
                PH_LENLO: begin
                    frame_len = {8'h00, b};
                    sum       = sum + b;
                    phase     = PH_LENHI;
                end
                PH_LENHI: begin
                    frame_len[15:8] = b;
                    sum             = sum + b;
                    if (frame_len > max_len) begin
                        post_outcome(ST_OVERSIZE, '0);
                        phase = PH_HDR1;
                    end else begin
                        phase = (frame_len == 16'd0) ? PH_CSUM : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    sum = sum + b;
                    if (body_count < CAPTURE_BYTES_DEF) param_bytes[8 * body_count +: 8] = b;
                    body_count = body_count + 16'd1;
                    if (body_count >= frame_len) phase = PH_CSUM;
                end
                PH_CSUM: begin
                    phase = PH_HDR1;
                    if (b != sum) begin
                        post_outcome(ST_CSUM_ERR, '0);
                    end else if (frame_type == type_code && frame_len == SET_PARAMS_LEN) begin
                        post_outcome(ST_ACCEPTED, param_bytes);
                    end else begin
                        post_outcome(ST_IGNORED, '0);
                    end
                end
                default: begin
                    phase = PH_HDR1;
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_outcome(status_t status, logic [87:0] data);
            result_t want;
            if (awaited.size() == 0) begin
                $error("frame outcome with none pending: status %0d, type 0x%0h",
                       status, data[7:0]);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("frame_status", 32'(want.frame_status), 32'(status));
            compare_field("frame_type", 32'(want.frame_type), 32'(data[7:0]));
            compare_field("payload_length", 32'(want.payload_length), 32'(data[23:8]));
            compare_field("timer_prescale", 32'(want.timer_prescale), 32'(data[39:24]));
            compare_field("timer_reload", 32'(want.timer_reload), 32'(data[55:40]));
            compare_field("tone_frequency", want.tone_frequency, data[87:56]);
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned bytes_sent     = 0;

    frame_outcome_tracker sb;

    checksummed_command_frame_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    initial begin
        #(64'd12 * 64'd400000);
        $display("*** FAILED ***");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_outcome(status_t'(m_tuser), m_tdata);
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.take_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len,
                              input logic [7:0] body[$], input bit corrupt, input int cut);
        logic [7:0] frame_bytes[$];
        logic [7:0] csum;
        frame_bytes = '{HDR_FIRST, HDR_SECOND, ftype, len[7:0], len[15:8]};
        csum = ftype + len[7:0] + len[15:8];
        if (len <= sb.max_len) begin
            foreach (body[i]) begin
                frame_bytes.push_back(body[i]);
                csum = csum + body[i];
            end
            frame_bytes.push_back(corrupt ? csum ^ 8'($urandom_range(255, 1)) : csum);
        end
        if (cut > 0 && cut < frame_bytes.size()) frame_bytes = frame_bytes[0:cut-1];
        foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    endtask

    task automatic send_random_frame();
        logic [7:0]  ftype;
        logic [15:0] len;
        logic [7:0]  body[$];
        int          pick;
        int          cut;
        pick  = $urandom_range(99);
        ftype = ($urandom_range(3) != 0) ? sb.type_code : 8'($urandom);
        if (pick < 40) begin
            len = SET_PARAMS_LEN;
        end else if (pick < 75) begin
            len = 16'($urandom_range(12));
        end else if (pick < 88 || sb.max_len == 16'hFFFF) begin
            len = 16'($urandom_range(40));
        end else begin
            len = 16'($urandom_range(16'hFFFF, sb.max_len + 1));
        end
        if (len <= sb.max_len) repeat (len) body.push_back(8'($urandom));
        cut = 0;
        if (sb.max_len < 16'd256 && $urandom_range(19) == 0) cut = $urandom_range(len + 5, 1);
        send_frame(ftype, len, body, $urandom_range(4) == 0, cut);
    endtask

    task automatic send_noise();
        logic [7:0] b;
        int         n;
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom);
            if (b == HDR_SECOND) b = HDR_FIRST;
            if (i == n - 1 && b == HDR_FIRST) b = ~b;
            send_byte(b);
        end
    endtask

    task automatic run_traffic(input int unsigned quota);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < quota) begin
            if ($urandom_range(9) == 0) send_noise();
            else send_random_frame();
        end
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_reg(input logic [7:0] reg_index, input logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(reg_index, value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [7:0] code, input logic [15:0] limit);
        settle();
        program_reg(REG_SET_PARAMS_TYPE, {8'($urandom), code});
        program_reg(REG_MAX_PAYLOAD_LEN, limit);
    endtask

    initial begin
        logic [7:0]  params[$];
        logic [7:0]  no_body[$];
        int unsigned guard;
        sb = new();
        params = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_frame(TYPE_CODE_RST, SET_PARAMS_LEN, params, 1'b0, 0);
        send_frame(TYPE_CODE_RST, 16'd0, no_body, 1'b1, 0);
        send_frame(8'hFF, 16'hFFFF, no_body, 1'b0, 0);
        send_byte(HDR_FIRST);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_frame(8'h7F, 16'd0, no_body, 1'b0, 0);

        send_gap_pct   = 21;
        recv_stall_pct = 60;
        configure(8'h00, 16'h0000);
        run_traffic(300);
        configure(8'hFF, 16'hFFFF);
        run_traffic(300);

        send_gap_pct   = 60;
        recv_stall_pct = 21;
        configure(8'($urandom), SET_PARAMS_LEN);
        run_traffic(320);
        configure(8'($urandom), SET_PARAMS_LEN - 16'd1);
        program_reg(8'($urandom_range(255, REG_MAX_PAYLOAD_LEN + 1)), 16'($urandom));
        run_traffic(320);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        configure(8'($urandom), 16'($urandom_range(200, 9)));
        run_traffic(320);
        configure(TYPE_CODE_RST, MAX_LEN_RST);
        run_traffic(320);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        for (guard = 0; guard < 20000 && sb.awaited.size() != 0; guard++) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (sb.awaited.size() != 0) begin
            $error("%0d frame outcomes never arrived", sb.awaited.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
design/cfcr_pkg.sv
design/cfcr_parser.sv
design/cfcr_out_skid.sv
design/checksummed_command_frame_receiver.sv
tb/tb_checksummed_command_frame_receiver.sv
